// File: hw/rtl/cat_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cat_pkg
// types and codes shared by the commit ack tracker modules
// ----------------------------------------------------------------------------
package cat_pkg;

	typedef enum logic [2:0] {
		KIND_SUBMIT  = 3'd0,
		KIND_ACK     = 3'd1,
		KIND_DURABLE = 3'd2,
		KIND_FLUSH   = 3'd3,
		KIND_QUERY   = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_BLOCKED = 2'd1,
		ST_FULL    = 2'd2,
		ST_IGNORED = 2'd3
	} status_t;

	localparam logic [1:0] MODE_STRONG   = 2'd0;
	localparam logic [1:0] MODE_LEADER   = 2'd1;
	localparam logic [1:0] MODE_ASYNC    = 2'd2;
	localparam logic [1:0] MODE_FLEXIBLE = 2'd3;

	localparam logic [1:0] REG_DEFAULT_MODE   = 2'd0;
	localparam logic [1:0] REG_ALLOW_OVERRIDE = 2'd1;
	localparam logic [1:0] REG_FLEXIBLE_ACKS  = 2'd2;
	localparam logic [1:0] REG_MAX_PENDING    = 2'd3;

	localparam int BYTES_W = 40;

	// one table entry as stored in memory
	typedef struct packed {
		logic [63:0] index;
		logic        flexible;
		logic [7:0]  acks;
		logic [7:0]  required;
		logic        done;
	} entry_t;

	// configuration seen by the sequencer
	typedef struct packed {
		logic [1:0]         default_mode;
		logic               allow_override;
		logic [7:0]         flexible_acks;
		logic [BYTES_W-1:0] max_pending;
	} cfg_t;

endpackage
`default_nettype wire

// File: hw/rtl/cat_cfg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cat_cfg
// configuration register bank
// ----------------------------------------------------------------------------
module cat_cfg (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          wr_en,
	input  wire logic [63:0]   wr_index,
	input  wire logic [63:0]   wr_data,
	output cat_pkg::cfg_t      cfg
);
	import cat_pkg::*;

	cfg_t cfg_q;

	// register writes, indexes beyond the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.default_mode   <= MODE_STRONG;
			cfg_q.allow_override <= 1'b1;
			cfg_q.flexible_acks  <= 8'd2;
			cfg_q.max_pending    <= BYTES_W'(1048576);
		end else if (wr_en && wr_index[63:2] == '0) begin
			unique case (wr_index[1:0])
				REG_DEFAULT_MODE:   cfg_q.default_mode   <= wr_data[1:0];
				REG_ALLOW_OVERRIDE: cfg_q.allow_override <= wr_data[0];
				REG_FLEXIBLE_ACKS:  cfg_q.flexible_acks  <= wr_data[7:0];
				REG_MAX_PENDING:    cfg_q.max_pending    <= wr_data[BYTES_W-1:0];
			endcase
		end
	end

	assign cfg = cfg_q;
endmodule
`default_nettype wire

// File: hw/rtl/cat_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cat_table
// entry memory, one write port and one registered read port
// ----------------------------------------------------------------------------
module cat_table #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  wire logic            clk,
	input  wire logic            we,
	input  wire logic [AW-1:0]   waddr,
	input  wire cat_pkg::entry_t wdata,
	input  wire logic [AW-1:0]   raddr,
	output cat_pkg::entry_t      rdata
);
	import cat_pkg::*;

	entry_t mem [DEPTH];
	entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;
endmodule
`default_nettype wire

// File: hw/rtl/commit_ack_tracker_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// commit_ack_tracker_top
// tracks log writes waiting for commit in a table memory
// ----------------------------------------------------------------------------
// channel  dir  handshake      payload
// in       in   valid/stall    kind, log_index, write_size, requested_mode
// out      out  valid/stall    status ... blocked
// cfg      in   valid/ready    index, data
//
// submit, query, flush-of-empty skip the walk; ack walks until its entry is found;
// durable and flush walk the table once, through the single memory read port
// (one entry read per cycle, compaction written in place).
// the result sits in an output register; the next beat is taken once it is
// taken. reset clears marks and counters; table contents need no clearing.
// ----------------------------------------------------------------------------
module commit_ack_tracker_top #(
	parameter int TABLE_DEPTH = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [2:0]  kind,
	input  wire logic [63:0] log_index,
	input  wire logic [23:0] write_size,
	input  wire logic [2:0]  requested_mode,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       status,
	output logic             should_ack,
	output logic [6:0]       flushed_count,
	output logic [63:0]      last_acked,
	output logic [63:0]      last_durable,
	output logic [6:0]       pending_entries,
	output logic             blocked,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [63:0] cfg_index,
	input  wire logic [63:0] cfg_data
);
	import cat_pkg::*;

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam logic [BYTES_W-1:0] BYTES_MAX = '1;

	typedef enum logic [1:0] {S_IDLE, S_WALK, S_DONE} state_t;

	cfg_t cfg;
	cat_cfg u_cfg (.clk, .arst_n, .wr_en(cfg_valid && cfg_ready),
		.wr_index(cfg_index), .wr_data(cfg_data), .cfg);
	assign cfg_ready = 1'b1;

	logic            we;
	logic [AW-1:0]   waddr, raddr;
	entry_t          wdata, rdata;
	cat_table #(.DEPTH(TABLE_DEPTH), .AW(AW)) u_tab (.clk, .we, .waddr, .wdata,
		.raddr, .rdata);

	state_t             state_q;
	kind_t              kind_q;
	logic [63:0]        idx_q;
	logic [CW-1:0]      count_q, rd_q, wr_q, n_q;
	logic               rvalid_q;
	logic [BYTES_W-1:0] bytes_q;
	logic [63:0]        acked_q, durable_q;
	logic               ovalid_q;
	logic [1:0]         status_q;
	logic               answer_q;
	logic [6:0]         flushed_q;

	// mode resolution and byte saturation for a submit
	logic [1:0]         mode;
	logic [BYTES_W:0]   bsum;
	assign mode = (cfg.allow_override && requested_mode[2] == 1'b0)
		? requested_mode[1:0] : cfg.default_mode;
	assign bsum = {1'b0, bytes_q} + {{(BYTES_W-24+1){1'b0}}, write_size};

	logic accept;
	assign in_stall = (state_q != S_IDLE) || ovalid_q;
	assign accept   = in_valid && !in_stall;

	// walk datapath: entry read last cycle arrives as rdata
	logic   hit, keep, ack_done;
	entry_t upd;
	logic [7:0] acks_inc;
	logic [CW-1:0] rd_prev;
	assign rd_prev = rd_q - CW'(1);
	always_comb begin
		acks_inc = (rdata.acks == 8'hff) ? rdata.acks : rdata.acks + 8'd1;
		upd  = rdata;
		hit  = 1'b0;
		keep = 1'b1;
		ack_done = 1'b0;
		unique case (kind_q)
			KIND_ACK: begin
				hit = rdata.index == idx_q;
				upd.acks = acks_inc;
				ack_done = rdata.flexible && rdata.required != 8'd0
					&& acks_inc >= rdata.required;
				upd.done = rdata.done || ack_done;
			end
			KIND_DURABLE: begin
				hit  = !rdata.done && !rdata.flexible && rdata.index <= idx_q;
				keep = !rdata.done && !hit;
			end
			default: hit = !rdata.done;
		endcase
	end

	always_comb begin
		we    = 1'b0;
		waddr = wr_q[AW-1:0];
		wdata = upd;
		raddr = rd_q[AW-1:0];
		if (accept && kind == KIND_SUBMIT) begin
			we = bytes_q < cfg.max_pending && (mode == MODE_STRONG || mode == MODE_FLEXIBLE)
				&& count_q < CW'(TABLE_DEPTH);
			waddr = count_q[AW-1:0];
			wdata.index    = log_index;
			wdata.flexible = mode == MODE_FLEXIBLE;
			wdata.acks     = 8'd1;
			wdata.required = (mode == MODE_FLEXIBLE) ? cfg.flexible_acks : 8'd0;
			wdata.done     = 1'b0;
		end else if (state_q == S_WALK && rvalid_q) begin
			if (kind_q == KIND_ACK) begin
				we = hit && !rdata.done;
				waddr = rd_prev[AW-1:0];
			end else if (kind_q == KIND_DURABLE) begin
				we = keep;
				wdata.done = 1'b0;
			end
		end
	end

	// sequencer, marks and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			kind_q    <= KIND_SUBMIT;
			idx_q     <= '0;
			count_q   <= '0;
			rd_q      <= '0;
			wr_q      <= '0;
			n_q       <= '0;
			rvalid_q  <= 1'b0;
			bytes_q   <= '0;
			acked_q   <= '0;
			durable_q <= '0;
			ovalid_q  <= 1'b0;
			status_q  <= ST_OK;
			answer_q  <= 1'b0;
			flushed_q <= '0;
		end else begin
			if (ovalid_q && !out_stall) ovalid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (accept) begin
					kind_q    <= kind_t'(kind);
					idx_q     <= log_index;
					rd_q      <= '0;
					wr_q      <= '0;
					n_q       <= '0;
					rvalid_q  <= 1'b0;
					status_q  <= ST_OK;
					answer_q  <= 1'b0;
					flushed_q <= '0;
					state_q   <= S_DONE;
					unique case (kind)
						KIND_SUBMIT: begin
							if (bytes_q >= cfg.max_pending) status_q <= ST_BLOCKED;
							else if (mode == MODE_LEADER || mode == MODE_ASYNC) begin
								if (log_index > acked_q) acked_q <= log_index;
							end else if (count_q >= CW'(TABLE_DEPTH)) status_q <= ST_FULL;
							else begin
								count_q <= count_q + CW'(1);
								bytes_q <= bsum[BYTES_W] ? BYTES_MAX : bsum[BYTES_W-1:0];
							end
						end
						KIND_ACK: begin
							status_q <= ST_IGNORED;
							if (count_q != '0) state_q <= S_WALK;
						end
						KIND_DURABLE: begin
							if (log_index <= durable_q) status_q <= ST_IGNORED;
							else begin
								durable_q <= log_index;
								if (count_q != '0) state_q <= S_WALK;
							end
						end
						KIND_FLUSH: begin
							bytes_q <= '0;
							if (count_q != '0) state_q <= S_WALK;
						end
						KIND_QUERY: answer_q <= log_index > acked_q && log_index <= durable_q;
						default: status_q <= ST_IGNORED;
					endcase
				end
				S_WALK: begin
					if (rd_q < count_q) rd_q <= rd_q + CW'(1);
					rvalid_q <= rd_q < count_q;
					if (rvalid_q) begin
						unique case (kind_q)
							KIND_ACK: if (hit) begin
								if (!rdata.done) begin
									status_q <= ST_OK;
									if (ack_done && idx_q > acked_q) acked_q <= idx_q;
								end
								state_q <= S_DONE;
							end
							KIND_DURABLE: begin
								if (hit && rdata.index > acked_q) acked_q <= rdata.index;
								if (keep) wr_q <= wr_q + CW'(1);
							end
							default: if (hit) begin
								n_q <= n_q + CW'(1);
								if (rdata.index > acked_q) acked_q <= rdata.index;
							end
						endcase
					end
					if (rvalid_q && rd_q == count_q && !(kind_q == KIND_ACK && hit)) begin
						state_q <= S_DONE;
						if (kind_q == KIND_DURABLE)
							count_q <= wr_q + CW'(keep);
						else if (kind_q == KIND_FLUSH) begin
							count_q   <= '0;
							flushed_q <= 7'(n_q + CW'(hit));
						end
					end
				end
				S_DONE: begin
					if (kind_q == KIND_FLUSH) count_q <= '0;
					ovalid_q <= 1'b1;
					state_q  <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid       = ovalid_q;
	assign status          = status_q;
	assign should_ack      = answer_q;
	assign flushed_count   = flushed_q;
	assign last_acked      = acked_q;
	assign last_durable    = durable_q;
	assign pending_entries = 7'(count_q);
	assign blocked         = bytes_q >= cfg.max_pending;

	// a new beat is never taken while a result waits
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ovalid_q |-> in_stall) else $error("beat accepted while result pending");
	// table never exceeds its depth
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(TABLE_DEPTH)) else $error("entry count over depth");
	// durable mark never moves down
	a_durable_mono: assert property (@(posedge clk) disable iff (!arst_n)
		durable_q >= $past(durable_q)) else $error("durable mark decreased");
endmodule
`default_nettype wire
